### sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mme_pkg.sv
// ---------------------------------------------------------------------------
// mme_pkg
// Shared types, widths and helpers of the matrix multiply engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM_DEF = 8;

    localparam int VAL_W     = 32;   // Q16.16 element
    localparam int FRAC_W    = 16;
    localparam int IDX_W     = 3;
    localparam int CMD_W     = 2;
    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W   = 40; // cmd, row, col, value
    localparam int M_TDATA_W   = 40; // row, col, value, pad
    localparam int OUT_VAL_LSB = 2 * IDX_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_LEFT  = 2'd0,
        CMD_LOAD_RIGHT = 2'd1,
        CMD_COMPUTE    = 2'd2
    } t_cmd;

    // Clamp a dimension register into 1..max_dim.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                  input int max_dim);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(max_dim);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > lim) begin
            return lim;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### sv/mme_ram.sv
// ---------------------------------------------------------------------------
// mme_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/matrix_multiply_engine.sv
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// Signed Q16.16 matrix multiply over two on-chip element stores.
// ---------------------------------------------------------------------------
// Load transfers (cmd 0 left, cmd 1 right) write one element into the left
// or right store; a load whose row or column is outside the configured size
// writes nothing and returns one result with tuser (bad index) and tlast set
// and a zero value. A compute transfer (cmd 2) emits the rows x cols product
// elements in row-major order, tlast on the final one. Each element streams
// inner_size operand pairs out of the two stores through one read port each
// into a single 32x32 multiplier and an exact wide accumulator, and a stalled
// output holds the product back. The sum is floored to Q16.16 and saturated
// to 32 bits.
// No input is taken while a product is in progress. Elements read by a
// compute must have been loaded since reset. Write the dimension registers
// only while the block is idle; 0 acts as 1 and values above MAX_DIM act as
// MAX_DIM.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [mme_pkg::DIM_W-1:0]           i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // cmd[1:0], row_index[4:2], col_index[7:5], element_value[39:8]
    input  wire logic [mme_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // out_row[2:0], out_col[5:3], out_value[37:6], zero pad[39:38]
    output logic      [mme_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                     m_axis_tlast,
    // bad_index[0]
    output logic                                     m_axis_tuser
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = mme_pkg::VAL_W;
    localparam int IW    = mme_pkg::IDX_W;
    localparam int DW    = mme_pkg::DIM_W;
    localparam int ACC_W = 2 * VW + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } t_state;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r,
                                             input logic [IW-1:0] c);
        logic [2*IW:0] lin;
        lin = (2*IW+1)'(r) * (2*IW+1)'(MAX_DIM) + (2*IW+1)'(c);
        return lin[AW-1:0];
    endfunction

    // configuration
    logic [DW-1:0] r_left_rows;
    logic [DW-1:0] r_inner_size;
    logic [DW-1:0] r_right_cols;
    logic [DW-1:0] w_nr;
    logic [DW-1:0] w_nk;
    logic [DW-1:0] w_nc;

    // input fields
    mme_pkg::t_cmd           w_cmd;
    logic [IW-1:0]           w_row;
    logic [IW-1:0]           w_col;
    logic [VW-1:0]           w_val;
    logic                    w_accept;
    logic                    w_out_free;
    logic [DW-1:0]           w_rlim;
    logic [DW-1:0]           w_clim;
    logic                    w_bad;
    logic                    w_left_we;
    logic                    w_right_we;
    logic [AW-1:0]           w_waddr;

    // sequencer and datapath
    t_state                  r_state;
    logic [IW-1:0]           r_i;
    logic [IW-1:0]           r_t;
    logic [IW-1:0]           r_q;
    logic                    r_rd_v;
    logic                    r_rd_first;
    logic                    r_rd_last;
    logic                    r_mul_v;
    logic                    r_mul_first;
    logic                    r_mul_last;
    logic signed [2*VW-1:0]  r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] w_shift;
    logic [VW-1:0]           w_sat;
    logic [VW-1:0]           w_left_q;
    logic [VW-1:0]           w_right_q;
    logic                    w_q_last;
    logic                    w_elem_final;
    logic                    w_t_last;

    // output register
    logic                    r_out_valid;
    logic [IW-1:0]           r_out_row;
    logic [IW-1:0]           r_out_col;
    logic [VW-1:0]           r_out_value;
    logic                    r_out_last;
    logic                    r_out_bad;
    logic                    w_out_load;

    assign w_nr = mme_pkg::eff_dim(r_left_rows, MAX_DIM);
    assign w_nk = mme_pkg::eff_dim(r_inner_size, MAX_DIM);
    assign w_nc = mme_pkg::eff_dim(r_right_cols, MAX_DIM);

    assign w_cmd = mme_pkg::t_cmd'(s_axis_tdata[mme_pkg::CMD_W-1:0]);
    assign w_row = s_axis_tdata[mme_pkg::CMD_W +: IW];
    assign w_col = s_axis_tdata[mme_pkg::CMD_W + IW +: IW];
    assign w_val = s_axis_tdata[mme_pkg::CMD_W + 2*IW +: VW];

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_rlim  = (w_cmd == mme_pkg::CMD_LOAD_LEFT) ? w_nr : w_nk;
    assign w_clim  = (w_cmd == mme_pkg::CMD_LOAD_LEFT) ? w_nk : w_nc;
    assign w_bad   = (DW'(w_row) >= w_rlim) || (DW'(w_col) >= w_clim);
    assign w_waddr = f_addr(w_row, w_col);

    assign w_left_we  = w_accept && (w_cmd == mme_pkg::CMD_LOAD_LEFT) && !w_bad;
    assign w_right_we = w_accept && (w_cmd == mme_pkg::CMD_LOAD_RIGHT) && !w_bad;

    // a bad-index load or a finished element fills the output register
    assign w_out_load = ((r_state == S_IDLE) && w_accept && w_bad &&
                         ((w_cmd == mme_pkg::CMD_LOAD_LEFT) ||
                          (w_cmd == mme_pkg::CMD_LOAD_RIGHT))) ||
                        ((r_state == S_EMIT) && w_out_free);

    // Loads happen only in idle and reads only during a product, so the
    // two never touch the same entry in overlapping cycles.
    mme_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_left_we),
        .i_waddr (w_waddr),
        .i_wdata (w_val),
        .i_raddr (f_addr(r_i, r_q)),
        .o_rdata (w_left_q)
    );

    mme_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_right_we),
        .i_waddr (w_waddr),
        .i_wdata (w_val),
        .i_raddr (f_addr(r_q, r_t)),
        .o_rdata (w_right_q)
    );

    assign w_q_last     = (DW'(r_q) + DW'(1)) == w_nk;
    assign w_t_last     = (DW'(r_t) + DW'(1)) == w_nc;
    assign w_elem_final = ((DW'(r_i) + DW'(1)) == w_nr) && w_t_last;

    // Exact accumulation; flooring falls out of the arithmetic shift.
    assign n_acc   = (r_mul_first ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
    assign w_shift = r_acc >>> mme_pkg::FRAC_W;

    always_comb begin
        if ((&w_shift[ACC_W-1:VW-1]) || !(|w_shift[ACC_W-1:VW-1])) begin
            w_sat = w_shift[VW-1:0];
        end else if (w_shift[ACC_W-1]) begin
            w_sat = {1'b1, {(VW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(VW-1){1'b1}}};
        end
    end

    // Payload pipeline: operands -> product -> accumulator.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_left_q) * $signed(w_right_q);
        if (r_mul_v) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_rows  <= mme_pkg::DIM_RESET;
            r_inner_size <= mme_pkg::DIM_RESET;
            r_right_cols <= mme_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mme_pkg::CFG_LEFT_ROWS:  r_left_rows  <= i_cfg_data;
                mme_pkg::CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                mme_pkg::CFG_RIGHT_COLS: r_right_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_t         <= '0;
            r_q         <= '0;
            r_rd_v      <= 1'b0;
            r_rd_first  <= 1'b0;
            r_rd_last   <= 1'b0;
            r_mul_v     <= 1'b0;
            r_mul_first <= 1'b0;
            r_mul_last  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_out_last  <= 1'b0;
            r_out_bad   <= 1'b0;
        end else begin
            // hold the result until taken, then drop it
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            r_rd_v      <= (r_state == S_ISSUE);
            r_mul_v     <= r_rd_v;
            r_mul_first <= r_rd_first;
            r_mul_last  <= r_rd_last;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_cmd)
                            mme_pkg::CMD_LOAD_LEFT, mme_pkg::CMD_LOAD_RIGHT: begin
                                if (w_bad) begin
                                    r_out_row   <= w_row;
                                    r_out_col   <= w_col;
                                    r_out_value <= '0;
                                    r_out_last  <= 1'b1;
                                    r_out_bad   <= 1'b1;
                                end
                            end
                            mme_pkg::CMD_COMPUTE: begin
                                r_i     <= '0;
                                r_t     <= '0;
                                r_q     <= '0;
                                r_state <= S_ISSUE;
                            end
                            default: ;
                        endcase
                    end
                end
                S_ISSUE: begin
                    r_rd_first <= (r_q == '0);
                    r_rd_last  <= w_q_last;
                    if (w_q_last) begin
                        r_q     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_q <= r_q + IW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_mul_v && r_mul_last) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_row   <= r_i;
                        r_out_col   <= r_t;
                        r_out_value <= w_sat;
                        r_out_last  <= w_elem_final;
                        r_out_bad   <= 1'b0;
                        if (w_elem_final) begin
                            r_state <= S_IDLE;
                        end else begin
                            // advance to the next element, row-major
                            if (w_t_last) begin
                                r_t <= '0;
                                r_i <= r_i + IW'(1);
                            end else begin
                                r_t <= r_t + IW'(1);
                            end
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(mme_pkg::M_TDATA_W - VW - 2*IW)'(0),
                            r_out_value, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_bad;

endmodule

`default_nettype wire

### sv/mme_checker.sv
// ---------------------------------------------------------------------------
// mme_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mme_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [mme_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast,
    input wire logic                          m_axis_tuser
);

    logic w_out_stall;
    logic w_bad_out;
    logic w_bad_zero;

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_bad_out   = m_axis_tvalid && m_axis_tuser;
    assign w_bad_zero  = m_axis_tdata[mme_pkg::OUT_VAL_LSB +: mme_pkg::VAL_W] == '0;

    // a stalled result must hold
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")

    `ASSERT_NOW(a_bad_is_last, i_clk, i_rst_n, w_bad_out, m_axis_tlast, "bad index result without tlast")

    `ASSERT_NOW(a_bad_is_zero, i_clk, i_rst_n, w_bad_out, w_bad_zero, "bad index result with nonzero value")

    // no input transfer while a result waits on a stalled output
    `ASSERT_NOW(a_no_take_on_stall, i_clk, i_rst_n, w_out_stall, !s_axis_tready, "input taken while output stalled")

    // an input transfer beside a pending result needs that result taken as well
    `ASSERT_NOW(a_in_accept_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && m_axis_tvalid, m_axis_tready, "input taken beside an unaccepted result")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
